// File: hw/rtl/sus_pkg.sv
package sus_pkg;

  // Store depth default and field widths
  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_OUT_W  = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic                     shift_in;  // accepted insert that will land
    logic signed [DATA_W-1:0] value;     // key being inserted or compared
  } cmd_t;

  // Per-cell compare result returned to the controller
  typedef struct packed {
    logic gt;  // cell holds a valid entry greater than the key
    logic eq;  // cell holds a valid entry equal to the key
  } cell_flags_t;

endpackage

// File: hw/rtl/sus_req_if.sv
interface sus_req_if import sus_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

// File: hw/rtl/sus_rsp_if.sv
interface sus_rsp_if import sus_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [DATA_W-1:0]      removed_value;
  logic        [STATUS_W-1:0]    status;
  logic        [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, removed_value, status, entry_count, input ready);
  modport sink   (input valid, removed_value, status, entry_count, output ready);
endinterface

// File: hw/rtl/sorted_unique_set_insert_remove_max.sv
// Sorted set of up to CAPACITY distinct signed 32-bit values held in a row of
// compare-and-shift cells. Every cell compares its entry with the incoming key
// in parallel and an insert shifts the larger entries up by one cell in the
// same cycle, so one transaction is taken every clock; its result appears in
// the output register on the next cycle. A remove returns the tail entry
// through a select across the row and only decrements the count. Input is
// accepted whenever the output register is empty or being drained, so back to
// back transactions run at one per cycle under no output stall. Refused inserts
// (duplicate or full) and removes from an empty set leave the contents intact.
module sorted_unique_set_insert_remove_max import sus_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  sus_req_if.sink  req,
  sus_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic signed [DATA_W-1:0] entry_vec [CAPACITY];
  cell_flags_t              flag_vec  [CAPACITY];
  logic [CAPACITY-1:0]      gt_vec;
  logic [CAPACITY-1:0]      eq_vec;
  logic [CAPACITY-1:0]      valid_vec;
  logic [CAPACITY-1:0]      tail_vec;
  cmd_t                     cmd;
  logic                     accept;
  logic                     dup;
  logic                     full;
  logic                     empty;
  logic signed [DATA_W-1:0] tail_value;
  logic [STATUS_W-1:0]      status_next;
  logic signed [DATA_W-1:0] removed_next;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     p_gt;
    logic signed [DATA_W-1:0] p_entry;

    assign valid_vec[i] = (count > CW'(i));
    assign tail_vec[i]  = (count == CW'(i + 1));
    assign gt_vec[i]    = flag_vec[i].gt;
    assign eq_vec[i]    = flag_vec[i].eq;

    if (i == 0) begin : g_first
      assign p_gt    = 1'b0;
      assign p_entry = cmd.value;
    end else begin : g_rest
      assign p_gt    = gt_vec[i-1];
      assign p_entry = entry_vec[i-1];
    end

    sus_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .valid      (valid_vec[i]),
      .prev_gt    (p_gt),
      .prev_entry (p_entry),
      .entry      (entry_vec[i]),
      .flags      (flag_vec[i])
    );
  end

  // Handshake and decision
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign dup       = |eq_vec;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    cmd.value    = req.value;
    cmd.shift_in = accept && (req.operation == OP_INSERT) && !dup && !full;
  end

  // Tail select for remove
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tail_vec[i]) begin
        tail_value = entry_vec[i];
      end
    end
  end

  // Status, removed value and next count
  always_comb begin
    count_next   = count;
    removed_next = '0;
    if (req.operation == OP_INSERT) begin
      if (dup) begin
        status_next = ST_DUPLICATE;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next  = ST_REMOVED;
        removed_next = tail_value;
        count_next   = count - 1'b1;
      end
    end
  end

  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

  // Count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.removed_value <= removed_next;
      rsp.status        <= status_next;
      rsp.entry_count   <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_in |=> (count == CW'($past(count) + 1'b1)))
    else $error("landed insert did not grow the count");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("count changed without a transaction");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted transaction produced no result");

  a_dup_no_shift: assert property (@(posedge clk) disable iff (rst)
    dup |-> !cmd.shift_in)
    else $error("duplicate value was inserted");

endmodule

// File: hw/rtl/sus_cell.sv
module sus_cell import sus_pkg::*; (
  input  logic                     clk,
  input  cmd_t                     cmd,
  input  logic                     valid,
  input  logic                     prev_gt,
  input  logic signed [DATA_W-1:0] prev_entry,
  output logic signed [DATA_W-1:0] entry,
  output cell_flags_t              flags
);

  // Compare own entry against the broadcast key
  always_comb begin
    flags.gt = valid && (entry > cmd.value);
    flags.eq = valid && (entry == cmd.value);
  end

  // Insert: entries above the key move up one cell; the first cell above
  // the key, and each empty cell not fed from below, takes the key itself
  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (flags.gt || !valid) begin
        entry <= cmd.value;
      end
    end
  end

endmodule
